>>> src/sspb_pkg.sv
// Shared constants, widths and types of the spherical stress profile binner.
// No dependencies; imported by the top level.
`default_nettype none

package sspb_pkg;

  localparam int NUM_BINS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 30;

  localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int END_W  = $clog2(NUM_BINS + 1);
  localparam int IDX_W  = 6;

  localparam int POS_W   = 32;
  localparam int BW_W    = 31;
  localparam int D_W     = 34;   // first + second - 2*center
  localparam int A_W     = 33;   // position - center
  localparam int SQ_W    = 68;   // sum of three squares
  localparam int ROOT_W  = 34;
  localparam int SQR_W   = 37;   // square-root partial remainder
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 70;
  localparam int UNIT_W  = 32;   // signed Q1.30
  localparam int DOT_W   = 35;
  localparam int ACC_W   = 66;
  localparam int NUM_W   = SQ_W + FRAC_BITS;
  localparam int REM_W   = 36;
  localparam int QUO_W   = 64;
  localparam int SUM_W   = 64;
  localparam int CNT_W   = $clog2(NUM_W + 3);
  localparam int J_W     = 4;

  localparam int IN_W       = 12 * POS_W;
  localparam int OUT_DATA_W = 200;
  localparam int ENTRY_W    = 3 * SUM_W;
  localparam int CFG_W      = 32;

  localparam int SQ_PRODS   = 9;
  localparam int UNIT_STEPS = D_W + UNIT_BITS;

  localparam logic [BW_W-1:0]   BIN_WIDTH_RST = BW_W'(65536);
  localparam logic [UNIT_W-1:0] UNIT_ONE      = UNIT_W'(1) << UNIT_BITS;
  localparam logic [SUM_W-1:0]  SUM_MAX       = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN       = {1'b1, {(SUM_W-1){1'b0}}};

  // square-root jobs
  localparam logic [J_W-1:0] SR_R   = 4'd0;
  localparam logic [J_W-1:0] SR_RHO = 4'd1;
  localparam logic [J_W-1:0] SR_R1  = 4'd2;
  localparam logic [J_W-1:0] SR_R2  = 4'd3;

  // divider jobs
  localparam logic [J_W-1:0] DV_SIN_T  = 4'd0;
  localparam logic [J_W-1:0] DV_COS_T  = 4'd1;
  localparam logic [J_W-1:0] DV_SIN_P  = 4'd2;
  localparam logic [J_W-1:0] DV_COS_P  = 4'd3;
  localparam logic [J_W-1:0] DV_BIN1   = 4'd4;
  localparam logic [J_W-1:0] DV_BIN2   = 4'd5;
  localparam logic [J_W-1:0] DV_PROJ_R = 4'd6;
  localparam logic [J_W-1:0] DV_PROJ_T = 4'd7;
  localparam logic [J_W-1:0] DV_PROJ_P = 4'd8;

  // dot-product jobs: bits [2:1] pick the direction, bit 0 force or separation
  localparam logic [J_W-1:0] DOT_LAST = 4'd5;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_BIN_WIDTH
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_PLAN,
    S_MULQ,
    S_DOT,
    S_RD,
    S_UPD,
    S_NULL
  } state_e;

endpackage

`default_nettype wire

>>> src/spherical_stress_profile_binning_top.sv
// Spherical stress profile binner: pair geometry, projections and bin RMW.
// Depends on sspb_pkg and sspb_ram.
//
// Usage:
//   s_axis carries one particle pair request (positions, separation, force).
//   m_axis returns one result per touched radial bin in ascending order, with
//   tlast on the final one; tuser is 1 for a real bin update. A pair that
//   touches no bin gives a single result with tuser 0 and zero data.
//   cfg_we_i writes center x/y/z or the bin width; write only while idle.
// Timing:
//   One pair at a time. Geometry runs four 34-step square roots, then four
//   64-step and two 34-step divides and three (68 + FRAC_BITS)-step projection
//   divides on one shared restoring divider, plus multiplies on one shared
//   35x35 multiplier. Each touched bin then takes a RAM read, then a modify
//   and write back.
// Reset:
//   Control and configuration registers return to their defaults and every bin reads as zero through
//   per-bin valid flags; no clearing pass is needed.
// Backpressure:
//   Results sit in one output register; while it is held the bin loop waits
//   before its next RAM read.
`default_nettype none

module spherical_stress_profile_binning_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // fields from bit 0: first_x/y/z, second_x/y/z, sep_x/y/z, force_x/y/z
  input  wire logic [sspb_pkg::IN_W-1:0]         s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // fields from bit 0: bin_index, radial_total, polar_total, azimuthal_total
  output logic [sspb_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // fields from bit 0: bin_valid
  output logic [0:0]                             m_axis_tuser_o,
  output logic                                   m_axis_tlast_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_addr_i,
  input  wire logic [sspb_pkg::CFG_W-1:0]        cfg_wdata_i
);

  import sspb_pkg::*;

  function automatic logic [PROD_W-1:0] rnd_unit(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    m = v[PROD_W-1] ? (~v + PROD_W'(1)) : v;
    m = (m + (PROD_W'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
    return v[PROD_W-1] ? (~m + PROD_W'(1)) : m;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
      s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    return s;
  endfunction

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [J_W-1:0]   j_q;

  logic signed [POS_W-1:0] cen_q [3];
  logic [BW_W-1:0]         bw_q;

  logic signed [POS_W-1:0] in_w [12];
  logic signed [D_W-1:0]   d_q  [3];
  logic signed [A_W-1:0]   a1_q [3];
  logic signed [A_W-1:0]   a2_q [3];
  logic signed [POS_W-1:0] s_q  [3];
  logic signed [POS_W-1:0] f_q  [3];

  logic [SQ_W-1:0]   r_sum_q, rho_sum_q, r1_sum_q, r2_sum_q;
  logic [ROOT_W-1:0] r_q, rho_q, r1_q, r2_q;
  logic [SQ_W-1:0]   rad_q;
  logic [SQR_W-1:0]  srem_q;
  logic [ROOT_W-1:0] sroot_q;
  logic [SQR_W+1:0]  sq_sh;
  logic [ROOT_W+1:0] sq_trial;

  logic [NUM_W-1:0]  dnum_q;
  logic [REM_W-1:0]  drem_q;
  logic [ROOT_W-1:0] dden_q;
  logic [QUO_W-1:0]  dquo_q;
  logic              dovf_q, dneg_q;
  logic [REM_W:0]    dv_sh;
  logic [CNT_W-1:0]  div_steps;
  logic              div_last, sqrt_last;
  logic [ROOT_W-1:0] dv_den_sel;
  logic [D_W-1:0]    dv_mag_sel;
  logic              dv_neg_sel;

  logic [ROOT_W-1:0] i1_q, i2_q;
  logic [ROOT_W-1:0] lo_w, hi_w, r12_w;
  logic [END_W-1:0]  end_w;
  logic              plan_go;
  logic [ROOT_W-1:0] r12_q;
  logic [END_W-1:0]  end_q;
  logic [BIN_AW-1:0] cur_q;
  logic              cur_last;

  logic signed [UNIT_W-1:0] st_q, ct_q, sp_q, cp_q, er0_q, er1_q, et0_q, et1_q;
  logic signed [DOT_W-1:0]  da_q [3];
  logic signed [DOT_W-1:0]  db_q [3];
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]         dot_sum;
  logic [PROD_W-1:0]        dot_rnd;
  logic [SUM_W-1:0]         vr_q, vt_q, vp_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b, e_comp, w_comp;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  logic [UNIT_W-1:0] uq;
  logic [UNIT_W-1:0] uval;
  logic [SUM_W-1:0]  pval;

  logic [NUM_BINS-1:0] vld_q;
  logic [ENTRY_W-1:0]  ram_rdata, ram_wdata, old_entry;
  logic [SUM_W-1:0]    new_r, new_t, new_p;

  logic out_vld_q, out_last_q, out_bv_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [SUM_W-1:0] out_r_q, out_t_q, out_p_q;
  logic in_acc, out_free;

  assign in_acc   = s_axis_tvalid_i && (state_q == S_IDLE);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      in_w[k] = s_axis_tdata_i[POS_W*k +: POS_W];
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      bw_q     <= BIN_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CENTER_X:  cen_q[0] <= cfg_wdata_i;
        REG_CENTER_Y:  cen_q[1] <= cfg_wdata_i;
        REG_CENTER_Z:  cen_q[2] <= cfg_wdata_i;
        REG_BIN_WIDTH: bw_q     <= cfg_wdata_i[BW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    e_comp = '0;
    w_comp = '0;
    case (j_q[2:1])
      2'd0: begin
        case (cnt_q)
          CNT_W'(0): e_comp = MUL_W'(er0_q);
          CNT_W'(1): e_comp = MUL_W'(er1_q);
          default:   e_comp = MUL_W'(ct_q);
        endcase
      end
      2'd1: begin
        case (cnt_q)
          CNT_W'(0): e_comp = MUL_W'(et0_q);
          CNT_W'(1): e_comp = MUL_W'(et1_q);
          default:   e_comp = -MUL_W'(st_q);
        endcase
      end
      default: begin
        case (cnt_q)
          CNT_W'(0): e_comp = -MUL_W'(sp_q);
          CNT_W'(1): e_comp = MUL_W'(cp_q);
          default:   e_comp = '0;
        endcase
      end
    endcase
    case (cnt_q)
      CNT_W'(0): w_comp = j_q[0] ? MUL_W'(s_q[0]) : MUL_W'(f_q[0]);
      CNT_W'(1): w_comp = j_q[0] ? MUL_W'(s_q[1]) : MUL_W'(f_q[1]);
      default:   w_comp = j_q[0] ? MUL_W'(s_q[2]) : MUL_W'(f_q[2]);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        case (cnt_q)
          CNT_W'(0): mul_a = MUL_W'(d_q[0]);
          CNT_W'(1): mul_a = MUL_W'(d_q[1]);
          CNT_W'(2): mul_a = MUL_W'(d_q[2]);
          CNT_W'(3): mul_a = MUL_W'(a1_q[0]);
          CNT_W'(4): mul_a = MUL_W'(a1_q[1]);
          CNT_W'(5): mul_a = MUL_W'(a1_q[2]);
          CNT_W'(6): mul_a = MUL_W'(a2_q[0]);
          CNT_W'(7): mul_a = MUL_W'(a2_q[1]);
          CNT_W'(8): mul_a = MUL_W'(a2_q[2]);
          default:   mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      S_MULQ: begin
        case (cnt_q)
          CNT_W'(0): begin mul_a = MUL_W'(st_q); mul_b = MUL_W'(cp_q); end
          CNT_W'(1): begin mul_a = MUL_W'(st_q); mul_b = MUL_W'(sp_q); end
          CNT_W'(2): begin mul_a = MUL_W'(ct_q); mul_b = MUL_W'(cp_q); end
          CNT_W'(3): begin mul_a = MUL_W'(ct_q); mul_b = MUL_W'(sp_q); end
          default: ;
        endcase
      end
      S_DOT: begin
        mul_a = e_comp;
        mul_b = w_comp;
      end
      S_DIV: begin
        // magnitudes of the two dot products for the projection numerator
        case (j_q)
          DV_PROJ_R: begin
            mul_a = da_q[0][DOT_W-1] ? -da_q[0] : da_q[0];
            mul_b = db_q[0][DOT_W-1] ? -db_q[0] : db_q[0];
          end
          DV_PROJ_T: begin
            mul_a = da_q[1][DOT_W-1] ? -da_q[1] : da_q[1];
            mul_b = db_q[1][DOT_W-1] ? -db_q[1] : db_q[1];
          end
          DV_PROJ_P: begin
            mul_a = da_q[2][DOT_W-1] ? -da_q[2] : da_q[2];
            mul_b = db_q[2][DOT_W-1] ? -db_q[2] : db_q[2];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ---------------- divider job selection ----------------
  always_comb begin
    dv_den_sel = r12_q;
    dv_mag_sel = '0;
    dv_neg_sel = 1'b0;
    div_steps  = CNT_W'(NUM_W);
    case (j_q)
      DV_SIN_T: begin
        dv_den_sel = r_q;
        dv_mag_sel = rho_q;
        div_steps  = CNT_W'(UNIT_STEPS);
      end
      DV_COS_T: begin
        dv_den_sel = r_q;
        dv_mag_sel = d_q[2][D_W-1] ? D_W'(-d_q[2]) : D_W'(d_q[2]);
        dv_neg_sel = d_q[2][D_W-1];
        div_steps  = CNT_W'(UNIT_STEPS);
      end
      DV_SIN_P: begin
        dv_den_sel = rho_q;
        dv_mag_sel = d_q[1][D_W-1] ? D_W'(-d_q[1]) : D_W'(d_q[1]);
        dv_neg_sel = d_q[1][D_W-1];
        div_steps  = CNT_W'(UNIT_STEPS);
      end
      DV_COS_P: begin
        dv_den_sel = rho_q;
        dv_mag_sel = d_q[0][D_W-1] ? D_W'(-d_q[0]) : D_W'(d_q[0]);
        dv_neg_sel = d_q[0][D_W-1];
        div_steps  = CNT_W'(UNIT_STEPS);
      end
      DV_BIN1, DV_BIN2: begin
        dv_den_sel = ROOT_W'(bw_q);
        div_steps  = CNT_W'(ROOT_W);
      end
      DV_PROJ_R: dv_neg_sel = da_q[0][DOT_W-1] ^ db_q[0][DOT_W-1];
      DV_PROJ_T: dv_neg_sel = da_q[1][DOT_W-1] ^ db_q[1][DOT_W-1];
      DV_PROJ_P: dv_neg_sel = da_q[2][DOT_W-1] ^ db_q[2][DOT_W-1];
      default: ;
    endcase
  end

  assign div_last  = (cnt_q == div_steps + CNT_W'(2));
  assign sqrt_last = (cnt_q == CNT_W'(ROOT_W + 1));

  assign dv_sh    = {drem_q, dnum_q[NUM_W-1]};
  assign sq_sh    = {srem_q, rad_q[SQ_W-1 -: 2]};
  assign sq_trial = {sroot_q, 2'b01};

  // unit-vector quotient, rounded half away from zero
  always_comb begin
    uq   = dquo_q[UNIT_W-1:0] +
           UNIT_W'({drem_q, 1'b0} >= (REM_W+1)'(dden_q));
    uval = dneg_q ? (~uq + UNIT_W'(1)) : uq;
    if (dneg_q) begin
      pval = (dovf_q || dquo_q[QUO_W-1]) ? SUM_MIN : (~dquo_q + SUM_W'(1));
    end else begin
      pval = (dovf_q || dquo_q[QUO_W-1]) ? SUM_MAX : dquo_q;
    end
  end

  // ---------------- bin range ----------------
  always_comb begin
    lo_w     = (i1_q < i2_q) ? i1_q : i2_q;
    hi_w     = (i1_q < i2_q) ? i2_q : i1_q;
    end_w    = (hi_w < ROOT_W'(NUM_BINS)) ? hi_w[END_W-1:0] : END_W'(NUM_BINS);
    r12_w    = (r1_q > r2_q) ? (r1_q - r2_q) : (r2_q - r1_q);
    plan_go  = (lo_w < ROOT_W'(end_w)) && (r12_w != '0);
    cur_last = ((END_W'(cur_q) + END_W'(1)) == end_q);
  end

  assign dot_sum = acc_q + prod_q[ACC_W-1:0];
  assign dot_rnd = rnd_unit(PROD_W'(signed'(dot_sum)));

  // ---------------- state machine ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_SQ;
      S_SQ:   if (cnt_q == CNT_W'(SQ_PRODS)) state_d = S_SQRT;
      S_SQRT: if (sqrt_last && j_q == SR_R2) state_d = S_DIV;
      S_DIV: begin
        if (div_last && j_q == DV_BIN2)   state_d = S_PLAN;
        if (div_last && j_q == DV_PROJ_P) state_d = S_RD;
      end
      S_PLAN: state_d = plan_go ? S_MULQ : S_NULL;
      S_MULQ: if (cnt_q == CNT_W'(4)) state_d = S_DOT;
      S_DOT:  if (cnt_q == CNT_W'(3) && j_q == DOT_LAST) state_d = S_DIV;
      S_RD:   if (out_free) state_d = S_UPD;
      S_UPD:  state_d = cur_last ? S_IDLE : S_RD;
      S_NULL: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      j_q   <= '0;
    end else begin
      case (state_q)
        S_SQ: begin
          cnt_q <= (cnt_q == CNT_W'(SQ_PRODS)) ? '0 : cnt_q + CNT_W'(1);
          j_q   <= '0;
        end
        S_SQRT: begin
          if (sqrt_last) begin
            cnt_q <= '0;
            j_q   <= (j_q == SR_R2) ? '0 : j_q + J_W'(1);
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DIV: begin
          if (div_last) begin
            cnt_q <= '0;
            j_q   <= j_q + J_W'(1);
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_MULQ: begin
          cnt_q <= (cnt_q == CNT_W'(4)) ? '0 : cnt_q + CNT_W'(1);
          j_q   <= '0;
        end
        S_DOT: begin
          // after the last dot product j lands on the first projection job
          if (cnt_q == CNT_W'(3)) begin
            cnt_q <= '0;
            j_q   <= j_q + J_W'(1);
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_PLAN: begin
          cnt_q <= '0;
          j_q   <= '0;
        end
        default: begin
          cnt_q <= '0;
          j_q   <= '0;
        end
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k]  <= D_W'(in_w[k]) + D_W'(in_w[3+k]) - (D_W'(cen_q[k]) <<< 1);
        a1_q[k] <= A_W'(in_w[k]) - A_W'(cen_q[k]);
        a2_q[k] <= A_W'(in_w[3+k]) - A_W'(cen_q[k]);
        s_q[k]  <= in_w[6+k];
        f_q[k]  <= in_w[9+k];
      end
    end

    case (state_q)
      S_SQ: begin
        case (cnt_q)
          CNT_W'(1): begin
            rho_sum_q <= prod_q[SQ_W-1:0];
            r_sum_q   <= prod_q[SQ_W-1:0];
          end
          CNT_W'(2): begin
            rho_sum_q <= rho_sum_q + prod_q[SQ_W-1:0];
            r_sum_q   <= r_sum_q + prod_q[SQ_W-1:0];
          end
          CNT_W'(3): r_sum_q  <= r_sum_q + prod_q[SQ_W-1:0];
          CNT_W'(4): r1_sum_q <= prod_q[SQ_W-1:0];
          CNT_W'(5), CNT_W'(6): r1_sum_q <= r1_sum_q + prod_q[SQ_W-1:0];
          CNT_W'(7): r2_sum_q <= prod_q[SQ_W-1:0];
          CNT_W'(8), CNT_W'(9): r2_sum_q <= r2_sum_q + prod_q[SQ_W-1:0];
          default: ;
        endcase
      end

      S_SQRT: begin
        if (cnt_q == '0) begin
          case (j_q)
            SR_R:    rad_q <= r_sum_q;
            SR_RHO:  rad_q <= rho_sum_q;
            SR_R1:   rad_q <= r1_sum_q;
            default: rad_q <= r2_sum_q;
          endcase
          srem_q  <= '0;
          sroot_q <= '0;
        end else if (!sqrt_last) begin
          // one root bit per cycle, two radicand bits in
          rad_q <= rad_q << 2;
          if (sq_sh >= (SQR_W+2)'(sq_trial)) begin
            srem_q  <= SQR_W'(sq_sh - (SQR_W+2)'(sq_trial));
            sroot_q <= {sroot_q[ROOT_W-2:0], 1'b1};
          end else begin
            srem_q  <= SQR_W'(sq_sh);
            sroot_q <= {sroot_q[ROOT_W-2:0], 1'b0};
          end
        end else begin
          case (j_q)
            SR_R:    r_q   <= sroot_q;
            SR_RHO:  rho_q <= sroot_q;
            SR_R1:   r1_q  <= sroot_q;
            default: r2_q  <= sroot_q;
          endcase
        end
      end

      S_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          case (j_q)
            DV_BIN1: dnum_q <= {r1_q, {(NUM_W-ROOT_W){1'b0}}};
            DV_BIN2: dnum_q <= {r2_q, {(NUM_W-ROOT_W){1'b0}}};
            DV_PROJ_R, DV_PROJ_T, DV_PROJ_P:
              dnum_q <= {prod_q[SQ_W-1:0], {FRAC_BITS{1'b0}}};
            default: dnum_q <= {dv_mag_sel, {(NUM_W-D_W){1'b0}}};
          endcase
          dden_q <= (dv_den_sel == '0) ? ROOT_W'(1) : dv_den_sel;
          dneg_q <= dv_neg_sel;
          drem_q <= '0;
          dquo_q <= '0;
          dovf_q <= 1'b0;
        end else if (cnt_q > CNT_W'(1) && !div_last) begin
          dnum_q <= dnum_q << 1;
          dovf_q <= dovf_q | dquo_q[QUO_W-1];
          if (dv_sh >= (REM_W+1)'(dden_q)) begin
            drem_q <= REM_W'(dv_sh - (REM_W+1)'(dden_q));
            dquo_q <= {dquo_q[QUO_W-2:0], 1'b1};
          end else begin
            drem_q <= REM_W'(dv_sh);
            dquo_q <= {dquo_q[QUO_W-2:0], 1'b0};
          end
        end else if (div_last) begin
          case (j_q)
            DV_SIN_T:  st_q <= (r_q == '0) ? '0 : uval;
            DV_COS_T:  ct_q <= (r_q == '0) ? UNIT_ONE : uval;
            DV_SIN_P:  sp_q <= (rho_q == '0) ? '0 : uval;
            DV_COS_P:  cp_q <= (rho_q == '0) ? UNIT_ONE : uval;
            DV_BIN1:   i1_q <= dquo_q[ROOT_W-1:0];
            DV_BIN2:   i2_q <= dquo_q[ROOT_W-1:0];
            DV_PROJ_R: vr_q <= pval;
            DV_PROJ_T: vt_q <= pval;
            DV_PROJ_P: vp_q <= pval;
            default: ;
          endcase
        end
      end

      S_PLAN: begin
        cur_q <= lo_w[BIN_AW-1:0];
        end_q <= end_w;
        r12_q <= r12_w;
      end

      S_MULQ: begin
        case (cnt_q)
          CNT_W'(1): er0_q <= UNIT_W'(rnd_unit(prod_q));
          CNT_W'(2): er1_q <= UNIT_W'(rnd_unit(prod_q));
          CNT_W'(3): et0_q <= UNIT_W'(rnd_unit(prod_q));
          CNT_W'(4): et1_q <= UNIT_W'(rnd_unit(prod_q));
          default: ;
        endcase
      end

      S_DOT: begin
        case (cnt_q)
          CNT_W'(1): acc_q <= prod_q[ACC_W-1:0];
          CNT_W'(2): acc_q <= dot_sum;
          CNT_W'(3): begin
            case ({j_q[2:1], j_q[0]})
              3'b000:  da_q[0] <= DOT_W'(dot_rnd);
              3'b001:  db_q[0] <= DOT_W'(dot_rnd);
              3'b010:  da_q[1] <= DOT_W'(dot_rnd);
              3'b011:  db_q[1] <= DOT_W'(dot_rnd);
              3'b100:  da_q[2] <= DOT_W'(dot_rnd);
              default: db_q[2] <= DOT_W'(dot_rnd);
            endcase
          end
          default: ;
        endcase
      end

      S_UPD: begin
        if (!cur_last) begin
          cur_q <= cur_q + BIN_AW'(1);
        end
      end

      default: ;
    endcase
  end

  // ---------------- bin store ----------------
  assign old_entry = vld_q[cur_q] ? ram_rdata : '0;
  assign new_r     = sat_add(old_entry[0 +: SUM_W], vr_q);
  assign new_t     = sat_add(old_entry[SUM_W +: SUM_W], vt_q);
  assign new_p     = sat_add(old_entry[2*SUM_W +: SUM_W], vp_q);
  assign ram_wdata = {new_p, new_t, new_r};

  sspb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPD),
    .waddr_i (cur_q),
    .wdata_i (ram_wdata),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == S_UPD) begin
      vld_q[cur_q] <= 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_UPD || (state_q == S_NULL && out_free)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      out_idx_q  <= IDX_W'(cur_q);
      out_r_q    <= new_r;
      out_t_q    <= new_t;
      out_p_q    <= new_p;
      out_bv_q   <= 1'b1;
      out_last_q <= cur_last;
    end else if (state_q == S_NULL && out_free) begin
      out_idx_q  <= '0;
      out_r_q    <= '0;
      out_t_q    <= '0;
      out_p_q    <= '0;
      out_bv_q   <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-IDX_W-3*SUM_W){1'b0}},
                            out_p_q, out_t_q, out_r_q, out_idx_q};
  assign m_axis_tuser_o  = out_bv_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> src/sspb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sspb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sim/tb_spherical_stress_profile_binning_top.sv
// Self-checking testbench for the spherical stress profile binner.
// Depends on sspb_pkg and spherical_stress_profile_binning_top; a built-in
// predictor models the pair geometry, projections and saturating bin sums.
`default_nettype none

module tb_spherical_stress_profile_binning_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sspb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 1500;
  localparam int HOLD_AT        = 150;
  localparam longint S64_MAX    = 64'h7fff_ffff_ffff_ffff;
  localparam longint S64_MIN    = 64'h8000_0000_0000_0000;

  typedef logic [11:0][31:0] pair_t;  // first_x..z, second_x..z, sep_x..z, force_x..z

  typedef struct {
    logic [5:0]  idx;
    logic [63:0] rad;
    logic [63:0] pol;
    logic [63:0] azi;
    logic        hit;
    logic        last;
  } bin_upd_t;

  logic               clk_i;
  logic               rst_ni;
  logic [IN_W-1:0]    s_tdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]         m_tuser;
  logic               m_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  spherical_stress_profile_binning_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] bin_w;
  longint      rad_sum [NUM_BINS];
  longint      pol_sum [NUM_BINS];
  longint      azi_sum [NUM_BINS];

  pair_t    pending_pairs[$];
  bin_upd_t expected_bins[$];
  int       errors;
  int       results_seen;
  bit       no_idle;

  function automatic logic [127:0] mag(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] res, c;
    res = '0;
    for (int b = 35; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  function automatic logic [127:0] norm3(input longint a, input longint b, input longint c);
    return isqrt(mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c));
  endfunction

  // Q1.30 ratio, rounded half away from zero
  function automatic longint unit_ratio(input longint v, input logic [127:0] den);
    logic [127:0] num, q, r;
    num = mag(v) << UNIT_BITS;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_q30(input longint v);
    logic [127:0] m;
    m = (mag(v) + (128'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint dot3(input longint e[3], input longint w[3]);
    return round_q30(e[0] * w[0] + e[1] * w[1] + e[2] * w[2]);
  endfunction

  function automatic longint stress_share(input longint e[3], input longint fv[3],
                                          input longint sv[3], input logic [127:0] den);
    longint a, b;
    logic [127:0] q;
    a = dot3(e, fv);
    b = dot3(e, sv);
    q = ((mag(a) * mag(b)) << FRAC_BITS) / den;
    if ((a < 0) != (b < 0))
      return (q >= (128'd1 << 63)) ? S64_MIN : -longint'(q[63:0]);
    return (q > 128'(S64_MAX)) ? S64_MAX : longint'(q[63:0]);
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
    return longint'(s[63:0]);
  endfunction

  function automatic void predict_bins(input pair_t p);
    longint c[3], p1[3], p2[3], sv[3], fv[3], d[3];
    longint st, ct, sp, cp, vr, vt, vp;
    longint er[3], et[3], ep[3];
    logic [127:0] r, rho, r1, r2, bw, i1, i2, lo, hi, stop, r12;
    bin_upd_t u;
    c[0] = longint'($signed(ctr_x));
    c[1] = longint'($signed(ctr_y));
    c[2] = longint'($signed(ctr_z));
    for (int k = 0; k < 3; k++) begin
      p1[k] = longint'($signed(p[k]));
      p2[k] = longint'($signed(p[3 + k]));
      sv[k] = longint'($signed(p[6 + k]));
      fv[k] = longint'($signed(p[9 + k]));
      d[k]  = p1[k] + p2[k] - 2 * c[k];
    end
    r   = norm3(d[0], d[1], d[2]);
    rho = norm3(d[0], d[1], 0);
    // midpoint at the center: polar angle zero
    if (r == 0) begin
      st = 0; ct = longint'(UNIT_ONE);
    end else begin
      st = unit_ratio(longint'(rho), r); ct = unit_ratio(d[2], r);
    end
    // midpoint on the z axis: azimuth zero
    if (rho == 0) begin
      sp = 0; cp = longint'(UNIT_ONE);
    end else begin
      sp = unit_ratio(d[1], rho); cp = unit_ratio(d[0], rho);
    end
    er[0] = round_q30(st * cp); er[1] = round_q30(st * sp); er[2] = ct;
    et[0] = round_q30(ct * cp); et[1] = round_q30(ct * sp); et[2] = -st;
    ep[0] = -sp; ep[1] = cp; ep[2] = 0;

    r1 = norm3(p1[0] - c[0], p1[1] - c[1], p1[2] - c[2]);
    r2 = norm3(p2[0] - c[0], p2[1] - c[1], p2[2] - c[2]);
    bw = (bin_w != 0) ? 128'(bin_w) : 128'd1;
    i1 = r1 / bw;
    i2 = r2 / bw;
    lo = (i1 < i2) ? i1 : i2;
    hi = (i1 < i2) ? i2 : i1;
    stop = (hi < NUM_BINS) ? hi : 128'(NUM_BINS);
    r12 = (r1 > r2) ? r1 - r2 : r2 - r1;

    if (lo < stop && r12 != 0) begin
      vr = stress_share(er, fv, sv, r12);
      vt = stress_share(et, fv, sv, r12);
      vp = stress_share(ep, fv, sv, r12);
      for (int i = int'(lo); i < int'(stop); i++) begin
        rad_sum[i] = sat_sum(rad_sum[i], vr);
        pol_sum[i] = sat_sum(pol_sum[i], vt);
        azi_sum[i] = sat_sum(azi_sum[i], vp);
        u.idx  = 6'(i);
        u.rad  = rad_sum[i];
        u.pol  = pol_sum[i];
        u.azi  = azi_sum[i];
        u.hit  = 1'b1;
        u.last = (i + 1 == int'(stop));
        expected_bins.push_back(u);
      end
    end else begin
      u = '{default: '0};
      u.last = 1'b1;
      expected_bins.push_back(u);
    end
  endfunction

  // request driver
  int    send_gap;
  pair_t cur_pair;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap = 0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_bins(cur_pair);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pairs.size() > 0) begin
          cur_pair = pending_pairs.pop_front();
          s_tdata <= cur_pair;
          nxt_valid = 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 12);
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // result monitor and checker
  int  recv_gap;
  int  hold_cnt;
  bit  held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    bin_upd_t e;
    logic [5:0]  a_idx;
    logic [63:0] a_rad, a_pol, a_azi;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      recv_gap = 0;
      hold_cnt = 0;
      held_once = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        a_idx = m_tdata[5:0];
        a_rad = m_tdata[69:6];
        a_pol = m_tdata[133:70];
        a_azi = m_tdata[197:134];
        results_seen++;
        if (expected_bins.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: bin %0d", a_idx);
        end else begin
          e = expected_bins.pop_front();
          if (a_idx !== e.idx || a_rad !== e.rad || a_pol !== e.pol || a_azi !== e.azi ||
              m_tuser[0] !== e.hit || m_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp bin %0d r %h p %h a %h v %b l %b | got bin %0d r %h p %h a %h v %b l %b",
                       e.idx, e.rad, e.pol, e.azi, e.hit, e.last,
                       a_idx, a_rad, a_pol, a_azi, m_tuser[0], m_tlast);
          end
        end
        recv_gap = no_idle ? 0 : $urandom_range(0, 12);
        if (!held_once && results_seen == HOLD_AT) begin
          held_once = 1;
          hold_cnt = LONG_HOLD;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("spherical_stress_profile_binning_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input cfg_reg_e a, input logic [31:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (a)
      REG_CENTER_X:  ctr_x = v;
      REG_CENTER_Y:  ctr_y = v;
      REG_CENTER_Z:  ctr_z = v;
      REG_BIN_WIDTH: bin_w = v[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_tvalid || expected_bins.size() > 0)
      @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_small(input int bits);
    return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // mostly pairs inside the binned shell around the center, some raw noise
  task automatic queue_random(input int n);
    pair_t p;
    longint span;
    span = longint'(bin_w) * 40;
    if (span > 64'd1 << 30) span = 64'd1 << 30;
    if (span < 4) span = 4;
    for (int j = 0; j < n; j++) begin
      for (int k = 0; k < 12; k++) p[k] = $urandom;
      if ($urandom_range(0, 9) != 0) begin
        for (int k = 0; k < 6; k++)
          p[k] = 32'(longint'($signed(k % 3 == 0 ? ctr_x : k % 3 == 1 ? ctr_y : ctr_z)) +
                     longint'($urandom_range(0, 32'(2 * span))) - span);
        if ($urandom_range(0, 2) != 0)
          for (int k = 6; k < 12; k++) p[k] = rnd_small($urandom_range(8, 24));
      end
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    pair_t p;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    errors = 0;
    results_seen = 0;
    no_idle = 0;
    ctr_x = '0; ctr_y = '0; ctr_z = '0;
    bin_w = BIN_WIDTH_RST;
    for (int i = 0; i < NUM_BINS; i++) begin
      rad_sum[i] = 0; pol_sum[i] = 0; azi_sum[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;

    // directed pairs with the reset settings
    p = '0;                                              // both at the center
    p[9] = 32'h0001_0000; p[6] = 32'h0001_0000;
    pending_pairs.push_back(p);
    p = '0; p[2] = 32'h0002_0000; p[5] = 32'h0028_0000;  // along z: no cylindrical radius
    p[8] = 32'h0001_0000; p[11] = 32'hfff0_0000;
    pending_pairs.push_back(p);
    p = '0; p[0] = 32'hffff_0000; p[3] = 32'h0001_0000;  // midpoint at center, equal radii: no bin
    p[6] = 32'h0002_0000; p[9] = 32'h0003_0000;
    pending_pairs.push_back(p);
    p = '0; p[0] = 32'h0000_8000; p[1] = 32'h0000_4000;  // same bin
    p[6] = 32'h0001_0000; p[9] = 32'h0001_0000;
    pending_pairs.push_back(p);
    p = '0; p[0] = 32'h0000_1000; p[4] = 32'h003f_8000;  // sweep of bins 0 to 62
    p[7] = 32'h003f_0000; p[10] = 32'h0100_0000;
    pending_pairs.push_back(p);
    p = '0; p[0] = 32'h0030_0000; p[3] = 32'h7fff_ffff;  // far end beyond the store
    p[6] = 32'h8000_0000; p[9] = 32'h7fff_ffff;
    pending_pairs.push_back(p);
    p = '0; p[0] = 32'h8000_0000; p[3] = 32'h7fff_ffff;  // both beyond the store
    pending_pairs.push_back(p);
    for (int j = 0; j < 4; j++) begin                    // drive sums into saturation
      p = '0; p[0] = 32'h0000_ffff; p[3] = 32'h0001_0000;
      p[6] = (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      p[7] = 32'h7fff_ffff; p[8] = 32'h8000_0000;
      p[9] = 32'h7fff_ffff; p[10] = 32'h8000_0000; p[11] = 32'h7fff_ffff;
      pending_pairs.push_back(p);
    end
    for (int k = 0; k < 12; k++) p[k] = 32'hffff_ffff;
    pending_pairs.push_back(p);
    for (int k = 0; k < 12; k++) p[k] = 32'h8000_0000;
    pending_pairs.push_back(p);
    drain();

    queue_random(120);
    drain();

    cfg_write(REG_CENTER_X, 32'h0003_0000);
    cfg_write(REG_CENTER_Y, 32'hfffb_8000);
    cfg_write(REG_CENTER_Z, 32'h0000_1234);
    cfg_write(REG_BIN_WIDTH, 32'h0000_4000);
    no_idle = 1;
    queue_random(80);
    drain();
    no_idle = 0;

    cfg_write(REG_BIN_WIDTH, 32'h0000_0001);
    queue_random(50);
    drain();

    cfg_write(REG_CENTER_X, 32'h8000_0000);
    cfg_write(REG_CENTER_Y, 32'h7fff_ffff);
    cfg_write(REG_CENTER_Z, 32'h8000_0000);
    cfg_write(REG_BIN_WIDTH, 32'h7fff_ffff);
    queue_random(60);
    drain();

    cfg_write(REG_CENTER_X, 32'h7fff_ffff);
    cfg_write(REG_CENTER_Y, 32'h8000_0000);
    cfg_write(REG_CENTER_Z, 32'h7fff_ffff);
    cfg_write(REG_BIN_WIDTH, 32'h0008_0000);
    queue_random(60);
    drain();

    cfg_write(REG_CENTER_X, $urandom);
    cfg_write(REG_CENTER_Y, $urandom);
    cfg_write(REG_CENTER_Z, $urandom);
    cfg_write(REG_BIN_WIDTH, 32'h0001_8000);
    queue_random(120);
    drain();

    if (errors == 0) begin
      $display("spherical_stress_profile_binning_top test passed");
    end else begin
      $display("spherical_stress_profile_binning_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
